// ===== src/spcp_pkg.sv =====
`default_nettype none
package spcp_pkg;

  // Operation codes of an input request.
  typedef enum logic [1:0] {
    OP_CODE  = 2'd0,
    OP_RAW   = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_FMT = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    KIND_ZERO,
    KIND_BIN,
    KIND_PAIR,
    KIND_SINGLE,
    KIND_GROUP,
    KIND_NONE
  } kind_t;

  localparam logic [4:0] FMT_ZERO    = 5'd0;
  localparam logic [4:0] FMT_BIN_LO  = 5'd3;
  localparam logic [4:0] FMT_BIN_HI  = 5'd16;
  localparam logic [4:0] FMT_PAIR1   = 5'd17;
  localparam logic [4:0] FMT_SINGLE1 = 5'd18;
  localparam logic [4:0] FMT_BASE3   = 5'd19;
  localparam logic [4:0] FMT_PAIR2   = 5'd20;
  localparam logic [4:0] FMT_SINGLE2 = 5'd21;
  localparam logic [4:0] FMT_BASE5   = 5'd22;
  localparam logic [4:0] FMT_PAIR3   = 5'd23;
  localparam logic [4:0] FMT_SINGLE3 = 5'd24;
  localparam logic [4:0] FMT_PAIR4   = 5'd26;
  localparam logic [4:0] FMT_SINGLE4 = 5'd27;
  localparam logic [4:0] FMT_BASE11  = 5'd29;

  localparam logic [4:0] RAW_MAX_BITS = 5'd16;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         format;
    logic signed [15:0] word;
    logic               last_in_column;
    logic [15:0]        raw_value;
    logic [4:0]         raw_width;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    status_t    status;
    logic       last_result;
  } out_res_t;

  // One coded request as it travels from the front to the back.
  typedef struct packed {
    logic [15:0] bits;
    logic [4:0]  len;
    status_t     status;
    logic        flush;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== src/spcp_front.sv =====
`default_nettype none
module spcp_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spcp_pkg::in_req_t in_data,
  input  wire logic              accept,
  output spcp_pkg::q_entry_t     code
);

  typedef struct packed {
    logic [1:0] len;
    logic [2:0] val;
  } mag_t;

  function automatic mag_t mag_code(input logic [2:0] pk, input logic signed [3:0] v);
    logic signed [3:0] s;
    logic [2:0]        m;
    mag_t              r;
    s = 4'sd0;
    m = 3'd0;
    if (pk == 3'd3) begin
      if (v == 4'sd1 || v == -4'sd1) begin
        r.val = {1'b0, v[3] ? 1'b0 : 1'b1, 1'b0};
        r.len = 2'd2;
      end else begin
        s = v[3] ? v + 4'sd3 : v;
        r.val = {s[1:0], 1'b1};
        r.len = 2'd3;
      end
    end else begin
      s = v[3] ? v + $signed({1'b0, pk}) : v + $signed({1'b0, pk}) - 4'sd1;
      case (pk)
        3'd1: begin
          m = 3'b001;
          r.len = 2'd1;
        end
        3'd2: begin
          m = 3'b011;
          r.len = 2'd2;
        end
        default: begin
          m = 3'b111;
          r.len = 2'd3;
        end
      endcase
      r.val = s[2:0] & m;
    end
    return r;
  endfunction

  spcp_pkg::kind_t    kind;
  logic [2:0]         peak;
  logic [2:0]         off;
  logic [3:0]         base;
  logic [1:0]         gsize;
  logic [4:0]         gwidth;
  logic [2:0]         lim;
  logic signed [16:0] w_ext;
  logic signed [16:0] lim_s;
  logic signed [16:0] mid;
  logic signed [16:0] bsum;
  logic signed [3:0]  wc;
  logic               clipped;
  mag_t               mag;
  logic [1:0]         fill_eff;
  logic [6:0]         gv_eff;
  logic [3:0]         digit;
  logic [6:0]         weight;
  logic [10:0]        gsum;
  logic [10:0]        gout;
  logic [1:0]         pos1;
  logic [6:0]         pad;
  logic [15:0]        val;
  logic [4:0]         len;
  logic [16:0]        mask;
  spcp_pkg::status_t  status;

  logic       zp_r, zp_nxt;
  logic [1:0] gfill_r, gfill_nxt;
  logic [6:0] gval_r, gval_nxt;

  always_comb begin
    kind   = spcp_pkg::KIND_NONE;
    peak   = 3'd0;
    off    = 3'd1;
    base   = 4'd3;
    gsize  = 2'd3;
    gwidth = 5'd5;
    case (in_data.format) inside
      spcp_pkg::FMT_ZERO: kind = spcp_pkg::KIND_ZERO;
      [spcp_pkg::FMT_BIN_LO:spcp_pkg::FMT_BIN_HI]: kind = spcp_pkg::KIND_BIN;
      spcp_pkg::FMT_PAIR1, spcp_pkg::FMT_PAIR2, spcp_pkg::FMT_PAIR3, spcp_pkg::FMT_PAIR4:
        kind = spcp_pkg::KIND_PAIR;
      spcp_pkg::FMT_SINGLE1, spcp_pkg::FMT_SINGLE2, spcp_pkg::FMT_SINGLE3,
      spcp_pkg::FMT_SINGLE4:
        kind = spcp_pkg::KIND_SINGLE;
      spcp_pkg::FMT_BASE3, spcp_pkg::FMT_BASE5, spcp_pkg::FMT_BASE11:
        kind = spcp_pkg::KIND_GROUP;
      default: kind = spcp_pkg::KIND_NONE;
    endcase
    case (in_data.format) inside
      spcp_pkg::FMT_PAIR1, spcp_pkg::FMT_SINGLE1: peak = 3'd1;
      spcp_pkg::FMT_PAIR2, spcp_pkg::FMT_SINGLE2: peak = 3'd2;
      spcp_pkg::FMT_PAIR3, spcp_pkg::FMT_SINGLE3: peak = 3'd3;
      default: peak = 3'd4;
    endcase
    case (in_data.format)
      spcp_pkg::FMT_BASE5: begin
        off    = 3'd2;
        base   = 4'd5;
        gsize  = 2'd3;
        gwidth = 5'd7;
      end
      spcp_pkg::FMT_BASE11: begin
        off    = 3'd5;
        base   = 4'd11;
        gsize  = 2'd2;
        gwidth = 5'd7;
      end
      default: begin
        off    = 3'd1;
        base   = 4'd3;
        gsize  = 2'd3;
        gwidth = 5'd5;
      end
    endcase

    // Saturate to the peak (or to the group offset) of the format.
    lim   = (kind == spcp_pkg::KIND_GROUP) ? off : peak;
    w_ext = {in_data.word[15], in_data.word};
    lim_s = $signed({14'd0, lim});
    clipped = 1'b1;
    if (w_ext > lim_s) begin
      wc = $signed({1'b0, lim});
    end else if (w_ext < -lim_s) begin
      wc = -$signed({1'b0, lim});
    end else begin
      wc = w_ext[3:0];
      clipped = 1'b0;
    end
    mag = mag_code(peak, wc);

    mid  = $signed(17'd1 << (in_data.format - 5'd1));
    bsum = w_ext + mid;

    fill_eff = (gfill_r >= gsize) ? 2'd0 : gfill_r;
    gv_eff   = (gfill_r >= gsize) ? 7'd0 : gval_r;
    digit    = unsigned'(wc + $signed({1'b0, off}));
    case (fill_eff)
      2'd0: weight = 7'd1;
      2'd1: weight = {3'd0, base};
      default: weight = {3'd0, base} * {3'd0, base};
    endcase
    gsum = {4'd0, gv_eff} + 11'(digit) * 11'(weight);
    pos1 = fill_eff + 2'd1;
    // Members missing at the close of a group count as zero (digit = offset).
    pad = 7'd0;
    if (pos1 != gsize) begin
      case (in_data.format)
        spcp_pkg::FMT_BASE3:  pad = (pos1 == 2'd1) ? 7'd12 : 7'd9;
        spcp_pkg::FMT_BASE5:  pad = (pos1 == 2'd1) ? 7'd60 : 7'd50;
        spcp_pkg::FMT_BASE11: pad = 7'd55;
        default: pad = 7'd0;
      endcase
    end
    gout = gsum + {4'd0, pad};

    val       = 16'd0;
    len       = 5'd0;
    status    = spcp_pkg::ST_OK;
    zp_nxt    = zp_r;
    gfill_nxt = gfill_r;
    gval_nxt  = gval_r;

    case (in_data.op)
      spcp_pkg::OP_CODE: begin
        if (kind == spcp_pkg::KIND_NONE) begin
          status = spcp_pkg::ST_BAD_FMT;
        end else begin
          if (kind != spcp_pkg::KIND_PAIR) begin
            zp_nxt = 1'b0;
          end
          if (kind != spcp_pkg::KIND_GROUP) begin
            gfill_nxt = 2'd0;
            gval_nxt  = 7'd0;
          end
          if (kind != spcp_pkg::KIND_ZERO && kind != spcp_pkg::KIND_BIN && clipped) begin
            status = spcp_pkg::ST_RANGE;
          end
          case (kind)
            spcp_pkg::KIND_ZERO: begin
              if (in_data.word != 16'sd0) begin
                status = spcp_pkg::ST_RANGE;
              end
            end
            spcp_pkg::KIND_BIN: begin
              if (w_ext < -mid || w_ext >= mid) begin
                status = spcp_pkg::ST_RANGE;
              end
              val = bsum[15:0];
              len = in_data.format;
            end
            spcp_pkg::KIND_SINGLE: begin
              if (wc == 4'sd0) begin
                len = 5'd1;
              end else begin
                val = {12'd0, mag.val, 1'b1};
                len = 5'd1 + 5'(mag.len);
              end
            end
            spcp_pkg::KIND_PAIR: begin
              zp_nxt = 1'b0;
              if (zp_r) begin
                if (wc == 4'sd0) begin
                  len = 5'd1;
                end else begin
                  // Held zero closes as a single zero, then the escape and value.
                  val = {9'd0, mag.val, 4'b1101};
                  len = 5'd4 + 5'(mag.len);
                end
              end else if (wc == 4'sd0) begin
                if (in_data.last_in_column) begin
                  val = 16'd1;
                  len = 5'd2;
                end else begin
                  zp_nxt = 1'b1;
                end
              end else begin
                val = {11'd0, mag.val, 2'b11};
                len = 5'd2 + 5'(mag.len);
              end
            end
            spcp_pkg::KIND_GROUP: begin
              if (pos1 == gsize || in_data.last_in_column) begin
                val       = {9'd0, gout[6:0]};
                len       = gwidth;
                gfill_nxt = 2'd0;
                gval_nxt  = 7'd0;
              end else begin
                gfill_nxt = pos1;
                gval_nxt  = gsum[6:0];
              end
            end
            default: begin
              len = 5'd0;
            end
          endcase
        end
      end
      spcp_pkg::OP_RAW: begin
        val = in_data.raw_value;
        len = (in_data.raw_width > spcp_pkg::RAW_MAX_BITS) ? spcp_pkg::RAW_MAX_BITS
                                                            : in_data.raw_width;
      end
      default: begin
        len = 5'd0;
      end
    endcase

    mask        = (17'd1 << len) - 17'd1;
    code.bits   = val & mask[15:0];
    code.len    = len;
    code.status = status;
    code.flush  = (in_data.op == spcp_pkg::OP_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r    <= 1'b0;
      gfill_r <= 2'd0;
      gval_r  <= 7'd0;
    end else if (accept) begin
      zp_r    <= zp_nxt;
      gfill_r <= gfill_nxt;
      gval_r  <= gval_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/spcp_queue.sv =====
`default_nettype none
module spcp_queue #(
  parameter int DEPTH = spcp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire spcp_pkg::q_entry_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output spcp_pkg::q_entry_t      pop_data,
  output logic                    nempty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spcp_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full     = (cnt_r == CW'(DEPTH));
    nempty   = (cnt_r != '0);
    pop_data = mem_r[rp_r];
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    case ({push, pop})
      2'b10: cnt_nxt = cnt_r + CW'(1);
      2'b01: cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/spcp_back.sv =====
`default_nettype none
module spcp_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire spcp_pkg::q_entry_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spcp_pkg::out_res_t      out_data
);

  logic [23:0]        acc_r, acc_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  spcp_pkg::status_t  status_r, status_nxt;
  logic               flush_r, flush_nxt;
  logic               out_valid_r, out_valid_nxt;
  spcp_pkg::out_res_t out_data_r, out_data_nxt;

  logic               out_ready;
  logic               step;
  logic [23:0]        acc_post;
  logic [4:0]         cnt_post;
  spcp_pkg::out_res_t res;
  logic [23:0]        base_acc;
  logic [4:0]         base_cnt;

  always_comb begin
    out_ready = !out_valid_r || !out_stall;
    step      = busy_r && out_ready;

    // One result per unstalled cycle: a whole byte, the padded partial byte of a
    // flush, or an empty result when the request completed nothing.
    res.status = status_r;
    if (cnt_r >= 5'd8) begin
      res.out_byte    = acc_r[7:0];
      res.byte_valid  = 1'b1;
      acc_post        = {8'd0, acc_r[23:8]};
      cnt_post        = cnt_r - 5'd8;
      res.last_result = (cnt_post < 5'd8);
    end else if (flush_r && cnt_r != 5'd0) begin
      res.out_byte    = acc_r[7:0];
      res.byte_valid  = 1'b1;
      acc_post        = 24'd0;
      cnt_post        = 5'd0;
      res.last_result = 1'b1;
    end else begin
      res.out_byte    = 8'd0;
      res.byte_valid  = 1'b0;
      acc_post        = acc_r;
      cnt_post        = cnt_r;
      res.last_result = 1'b1;
    end

    base_acc = busy_r ? acc_post : acc_r;
    base_cnt = busy_r ? cnt_post : cnt_r;
    q_pop    = q_valid && (!busy_r || (step && res.last_result));

    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    status_nxt = status_r;
    flush_nxt  = flush_r;
    if (step) begin
      acc_nxt  = acc_post;
      cnt_nxt  = cnt_post;
      busy_nxt = !res.last_result;
    end
    if (q_pop) begin
      acc_nxt    = base_acc | (24'(q_data.bits) << base_cnt);
      cnt_nxt    = base_cnt + q_data.len;
      busy_nxt   = 1'b1;
      status_nxt = q_data.status;
      flush_nxt  = q_data.flush;
    end

    out_valid_nxt = step || (out_valid_r && out_stall);
    out_data_nxt  = step ? res : out_data_r;

    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    flush_r    <= flush_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 24'd0;
      cnt_r       <= 5'd0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/subband_coefficient_packer.sv =====
`default_nettype none
// Channel  Handshake             Payload               Direction
// in       in_valid / in_stall   spcp_pkg::in_req_t    into the block
// out      out_valid / out_stall spcp_pkg::out_res_t   out of the block
//
// Each request gives one or two results. The back end emits one result per cycle
// through its byte output register while out_stall is low. An accepted request
// passes through the queue and the bit accumulator into the output register.
// Synchronous active-low reset clears the bit accumulator, held zero, partial group
// and the queue. in_stall rises only when the queue between front and back is full;
// out_stall holds the output register while requests fill the queue.
module subband_coefficient_packer #(
  parameter int QUEUE_DEPTH = spcp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire spcp_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output spcp_pkg::out_res_t     out_data
);

  spcp_pkg::q_entry_t f_code;
  spcp_pkg::q_entry_t q_head;
  logic               q_full;
  logic               q_nempty;
  logic               q_pop;
  logic               q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  spcp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .accept  (q_push),
    .code    (f_code)
  );

  spcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_code),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .nempty    (q_nempty)
  );

  spcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nempty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An empty result always closes its request and carries a zero byte.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.last_result && out_data.out_byte == 8'd0)
    else $error("empty result not marked last");

  // The second byte of a request follows at once, is last and keeps the status.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result |=>
      out_valid && out_data.last_result && out_data.byte_valid &&
      out_data.status == $past(out_data.status))
    else $error("second result of a request missing or malformed");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nempty)
    else $error("queue popped while empty");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

endmodule
`default_nettype wire
